>>> hw/rtl/skt_pkg.sv
// ---------------------------------------------------------------------------
// Sorted key table package
// Sizes, operation and status codes, and the stored entry type.
// ---------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_BITS  = 8;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } entry_t;

endpackage

>>> hw/rtl/sorted_key_table_top.sv
// ---------------------------------------------------------------------------
// Sorted key table
// Up to DEPTH key/payload entries kept in ascending key order in one
// synchronous memory, with insert, remove, lookup and update requests.
// ---------------------------------------------------------------------------
//
//  Channel | Ports                                            | Direction
//  --------+--------------------------------------------------+----------
//  request | in_valid, in_ready, in_operation, in_key,        | in
//          | in_payload                                       |
//  result  | out_valid, out_ready, out_status, out_found,     | out
//          | out_read_data, out_entry_count                   |
//
// A request is accepted, then the scan reads one entry per step, an insert
// adds a write step, and the result is then loaded. An insert visits at most
// DEPTH - 1 entries and the other requests at most DEPTH, as the memory has a
// single read port.
// Reset clears the entry count and the control state; the memory holds no
// reset value and is only read below the entry count.
// A stalled result holds the block in its response step; the next request
// is taken as soon as the previous result has been loaded.
module sorted_key_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [skt_pkg::KEY_BITS-1:0]  in_key,
  input  logic [skt_pkg::DATA_BITS-1:0] in_payload,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic [skt_pkg::DATA_BITS-1:0] out_read_data,
  output logic [skt_pkg::CNT_W-1:0]     out_entry_count
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PUT  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  // Entry storage: one write and one registered read per cycle.
  skt_pkg::entry_t entry_mem [skt_pkg::DEPTH];
  skt_pkg::entry_t rd_entry_r;

  state_t                          state_r, state_nxt;
  logic [1:0]                      op_r, op_nxt;
  logic [skt_pkg::KEY_BITS-1:0]    key_r, key_nxt;
  logic [skt_pkg::DATA_BITS-1:0]   data_r, data_nxt;
  logic [skt_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [skt_pkg::IDX_W-1:0]       pos_r, pos_nxt;
  logic                            found_r, found_nxt;
  logic [skt_pkg::DATA_BITS-1:0]   read_r, read_nxt;
  logic [1:0]                      status_r, status_nxt;
  logic [skt_pkg::CNT_W-1:0]       count_r, count_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [skt_pkg::DATA_BITS-1:0]   out_read_r, out_read_nxt;
  logic [skt_pkg::CNT_W-1:0]       out_count_r, out_count_nxt;

  logic                            mem_we;
  logic [skt_pkg::IDX_W-1:0]       mem_wa;
  skt_pkg::entry_t                 mem_wd;
  logic [skt_pkg::IDX_W-1:0]       rd_addr;

  logic [skt_pkg::IDX_W-1:0]       last_idx;
  logic                            key_match;
  logic                            key_ge;
  logic                            is_last;
  logic                            out_free;

  assign in_ready = (state_r == S_IDLE);

  // Index of the last valid entry; only used when the table is not empty.
  assign last_idx  = skt_pkg::IDX_W'(count_r - skt_pkg::CNT_W'(1));
  assign key_match = (rd_entry_r.key == key_r);
  assign key_ge    = (rd_entry_r.key >= key_r);
  assign is_last   = (idx_r == last_idx);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    data_nxt       = data_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    read_nxt       = read_r;
    status_nxt     = status_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_read_nxt   = out_read_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = idx_r;
    mem_wd         = rd_entry_r;
    rd_addr        = idx_r + skt_pkg::IDX_W'(1);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          key_nxt    = in_key;
          data_nxt   = in_payload;
          found_nxt  = 1'b0;
          read_nxt   = '0;
          status_nxt = skt_pkg::ST_OK;
          if (in_operation == skt_pkg::OP_INSERT) begin
            if (count_r == skt_pkg::CNT_W'(skt_pkg::DEPTH)) begin
              status_nxt = skt_pkg::ST_FULL;
              state_nxt  = S_RESP;
            end else if (count_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_PUT;
            end else begin
              // Inserts walk down from the tail, shifting each entry up whose key is not below the new one.
              idx_nxt   = last_idx;
              rd_addr   = last_idx;
              state_nxt = S_SCAN;
            end
          end else if (count_r == '0) begin
            status_nxt = skt_pkg::ST_EMPTY;
            state_nxt  = S_RESP;
          end else begin
            idx_nxt   = '0;
            rd_addr   = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (op_r == skt_pkg::OP_INSERT) begin
          rd_addr = idx_r - skt_pkg::IDX_W'(1);
          if (idx_r != '0) begin
            if (key_ge) begin
              mem_we  = 1'b1;
              mem_wa  = idx_r + skt_pkg::IDX_W'(1);
              idx_nxt = idx_r - skt_pkg::IDX_W'(1);
            end else begin
              pos_nxt   = idx_r + skt_pkg::IDX_W'(1);
              state_nxt = S_PUT;
            end
          end else begin
            // The head entry moves only if the new key is strictly below it.
            if (key_r < rd_entry_r.key) begin
              mem_we  = 1'b1;
              mem_wa  = skt_pkg::IDX_W'(1);
              pos_nxt = '0;
            end else begin
              pos_nxt = skt_pkg::IDX_W'(1);
            end
            state_nxt = S_PUT;
          end
        end else begin
          idx_nxt = idx_r + skt_pkg::IDX_W'(1);
          case (op_r)
            skt_pkg::OP_REMOVE: begin
              if (found_r) begin
                mem_we = 1'b1;
                mem_wa = idx_r - skt_pkg::IDX_W'(1);
              end else if (key_match) begin
                found_nxt = 1'b1;
              end
            end
            skt_pkg::OP_LOOKUP: begin
              if (key_match) begin
                found_nxt = 1'b1;
                read_nxt  = rd_entry_r.payload;
              end
            end
            default: begin
              if (key_match) begin
                found_nxt      = 1'b1;
                mem_we         = 1'b1;
                mem_wd.payload = data_r;
              end
            end
          endcase
          if (is_last) begin
            status_nxt = found_nxt ? skt_pkg::ST_OK : skt_pkg::ST_MISSING;
            if ((op_r == skt_pkg::OP_REMOVE) && found_nxt) begin
              count_nxt = count_r - skt_pkg::CNT_W'(1);
            end
            state_nxt = S_RESP;
          end
        end
      end

      S_PUT: begin
        mem_we         = 1'b1;
        mem_wa         = pos_r;
        mem_wd.key     = key_r;
        mem_wd.payload = data_r;
        count_nxt      = count_r + skt_pkg::CNT_W'(1);
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_read_nxt   = read_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
    rd_entry_r <= entry_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    data_r       <= data_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    read_r       <= read_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_read_r   <= out_read_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_read_data   = out_read_r;
  assign out_entry_count = out_count_r;

  // The entry count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= skt_pkg::CNT_W'(skt_pkg::DEPTH))
    else $error("entry count above depth");

  // The memory is only written while scanning or placing a new entry.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SCAN || state_r == S_PUT))
    else $error("memory write outside scan or put");

  // An insert into a full table goes straight to the response with full status.
  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == skt_pkg::OP_INSERT &&
     count_r == skt_pkg::CNT_W'(skt_pkg::DEPTH))
    |=> (state_r == S_RESP && status_r == skt_pkg::ST_FULL))
    else $error("full insert not refused");

  // The count only moves at the end of a scan or at the insert write.
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
    ($past(state_r) == S_SCAN || $past(state_r) == S_PUT))
    else $error("entry count changed outside an operation");

endmodule
